>>> design/mlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

	// Width of the coordinate fields on the ports
	localparam int FIELD_BITS = 11;
	// Width of the internal coordinate registers
	localparam int COORD_BITS = 11;
	// Decision variable and its increments
	localparam int DEC_BITS = COORD_BITS + 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		OCT_SHALLOW_UP   = 2'd0,
		OCT_SHALLOW_DOWN = 2'd1,
		OCT_STEEP_UP     = 2'd2,
		OCT_STEEP_DOWN   = 2'd3
	} octant_t;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DEC_BITS-1:0] dec_t;

	// One classified command, as it waits between front and back
	typedef struct packed {
		logic    is_start;
		logic    last;
		octant_t octant;
		coord_t  x0;
		coord_t  y0;
		coord_t  stop;
		dec_t    decision;
		dec_t    incr_one;
		dec_t    incr_two;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

>>> design/mlr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mlr_cmd_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [mlr_pkg::FIELD_BITS-1:0] start_x;
	logic [mlr_pkg::FIELD_BITS-1:0] start_y;
	logic [mlr_pkg::FIELD_BITS-1:0] end_x;
	logic [mlr_pkg::FIELD_BITS-1:0] end_y;

	modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_pix_if;
	logic                            valid;
	logic                            ready;
	logic [mlr_pkg::FIELD_BITS-1:0] pixel_x;
	logic [mlr_pkg::FIELD_BITS-1:0] pixel_y;
	logic                            last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

>>> design/mlr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mlr_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic                 cfg_write_data,
	mlr_cmd_if.sink                   cmd,
	input  wire mlr_pkg::queue_stat_t qstat,
	output logic                      push,
	output mlr_pkg::entry_t           push_entry
);

	logic draw_enable_q;

	mlr_pkg::coord_t sx, sy, ex, ey, x0, y0, x1, y1;
	logic signed [mlr_pkg::DEC_BITS-1:0] x0e, y0e, x1e, y1e, a, b, dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_enable_q <= 1'b0;
		end else if (cfg_write_en) begin
			draw_enable_q <= cfg_write_data;
		end
	end

	assign cmd.ready = !qstat.full;

	// Drop start commands while drawing is off
	assign push = cmd.valid && cmd.ready &&
		(cmd.command == mlr_pkg::CMD_ADVANCE || draw_enable_q);

	always_comb begin
		sx = mlr_pkg::COORD_BITS'(cmd.start_x);
		sy = mlr_pkg::COORD_BITS'(cmd.start_y);
		ex = mlr_pkg::COORD_BITS'(cmd.end_x);
		ey = mlr_pkg::COORD_BITS'(cmd.end_y);
		// Swap so that x never decreases
		if (ex < sx) begin
			x0 = ex; y0 = ey; x1 = sx; y1 = sy;
		end else begin
			x0 = sx; y0 = sy; x1 = ex; y1 = ey;
		end
		x0e = $signed(mlr_pkg::DEC_BITS'(x0));
		y0e = $signed(mlr_pkg::DEC_BITS'(y0));
		x1e = $signed(mlr_pkg::DEC_BITS'(x1));
		y1e = $signed(mlr_pkg::DEC_BITS'(y1));
		a  = y0e - y1e;
		b  = x1e - x0e;
		dy = y1e - y0e;

		push_entry.is_start = (cmd.command == mlr_pkg::CMD_START);
		push_entry.x0 = x0;
		push_entry.y0 = y0;
		if (dy >= 0 && dy <= b) begin
			push_entry.octant   = mlr_pkg::OCT_SHALLOW_UP;
			push_entry.decision = (a <<< 1) + b;
			push_entry.incr_one = a <<< 1;
			push_entry.incr_two = (a + b) <<< 1;
			push_entry.stop     = x1;
			push_entry.last     = (x0 == x1);
		end else if (dy < 0 && dy >= -b) begin
			push_entry.octant   = mlr_pkg::OCT_SHALLOW_DOWN;
			push_entry.decision = (a <<< 1) - b;
			push_entry.incr_one = (a - b) <<< 1;
			push_entry.incr_two = a <<< 1;
			push_entry.stop     = x1;
			push_entry.last     = (x0 == x1);
		end else if (dy > b) begin
			push_entry.octant   = mlr_pkg::OCT_STEEP_UP;
			push_entry.decision = a + (b <<< 1);
			push_entry.incr_one = (a + b) <<< 1;
			push_entry.incr_two = b <<< 1;
			push_entry.stop     = y1;
			push_entry.last     = (y0 == y1);
		end else begin
			push_entry.octant   = mlr_pkg::OCT_STEEP_DOWN;
			push_entry.decision = a - (b <<< 1);
			push_entry.incr_one = -(b <<< 1);
			push_entry.incr_two = (a - b) <<< 1;
			push_entry.stop     = y1;
			push_entry.last     = (y0 == y1);
		end
	end

endmodule

`default_nettype wire

>>> design/mlr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mlr_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire mlr_pkg::entry_t       push_entry,
	input  wire logic                  pop,
	output mlr_pkg::entry_t            pop_entry,
	output mlr_pkg::queue_stat_t       qstat
);

	mlr_pkg::entry_t                  slot_q [mlr_pkg::QUEUE_DEPTH];
	logic [mlr_pkg::QPTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
	logic [mlr_pkg::QCNT_BITS-1:0]    count_q;

	function automatic logic [mlr_pkg::QPTR_BITS-1:0] next_ptr(
		input logic [mlr_pkg::QPTR_BITS-1:0] p);
		if (p == mlr_pkg::QPTR_BITS'(mlr_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign qstat.full  = (count_q == mlr_pkg::QCNT_BITS'(mlr_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_entry   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

>>> design/mlr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mlr_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mlr_pkg::entry_t      pop_entry,
	input  wire mlr_pkg::queue_stat_t qstat,
	output logic                      pop,
	mlr_pix_if.source                 pix
);

	mlr_pkg::coord_t                     cur_x_q, cur_y_q, stop_q;
	logic signed [mlr_pkg::DEC_BITS-1:0] dec_q, incr_one_q, incr_two_q;
	mlr_pkg::octant_t                    octant_q;
	logic                                active_q, valid_q, last_q;

	mlr_pkg::coord_t                     nx, ny;
	logic signed [mlr_pkg::DEC_BITS-1:0] nd;
	logic                                adv_last;

	// Take the next transaction when the output register is free or draining
	assign pop = !qstat.empty && (!valid_q || pix.ready);

	assign pix.valid      = valid_q;
	assign pix.pixel_x    = mlr_pkg::FIELD_BITS'(cur_x_q);
	assign pix.pixel_y    = mlr_pkg::FIELD_BITS'(cur_y_q);
	assign pix.last_pixel = last_q;

	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		nd = dec_q;
		unique case (octant_q)
			mlr_pkg::OCT_SHALLOW_UP: begin
				nx = cur_x_q + 1'b1;
				if (dec_q <= 0) begin
					ny = cur_y_q + 1'b1;
					nd = dec_q + incr_two_q;
				end else begin
					nd = dec_q + incr_one_q;
				end
			end
			mlr_pkg::OCT_SHALLOW_DOWN: begin
				nx = cur_x_q + 1'b1;
				if (dec_q > 0) begin
					ny = cur_y_q - 1'b1;
					nd = dec_q + incr_one_q;
				end else begin
					nd = dec_q + incr_two_q;
				end
			end
			mlr_pkg::OCT_STEEP_UP: begin
				ny = cur_y_q + 1'b1;
				if (dec_q > 0) begin
					nx = cur_x_q + 1'b1;
					nd = dec_q + incr_one_q;
				end else begin
					nd = dec_q + incr_two_q;
				end
			end
			default: begin
				ny = cur_y_q - 1'b1;
				if (dec_q <= 0) begin
					nx = cur_x_q + 1'b1;
					nd = dec_q + incr_two_q;
				end else begin
					nd = dec_q + incr_one_q;
				end
			end
		endcase
		if (octant_q == mlr_pkg::OCT_SHALLOW_UP || octant_q == mlr_pkg::OCT_SHALLOW_DOWN)
			adv_last = (nx == stop_q);
		else
			adv_last = (ny == stop_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else if (pop) begin
			if (pop_entry.is_start) begin
				active_q <= !pop_entry.last;
				valid_q  <= 1'b1;
			end else if (active_q) begin
				active_q <= !adv_last;
				valid_q  <= 1'b1;
			end else begin
				// Advance with no line in progress: drop it
				valid_q <= 1'b0;
			end
		end else if (pix.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_entry.is_start) begin
				cur_x_q    <= pop_entry.x0;
				cur_y_q    <= pop_entry.y0;
				stop_q     <= pop_entry.stop;
				dec_q      <= $signed(pop_entry.decision);
				incr_one_q <= $signed(pop_entry.incr_one);
				incr_two_q <= $signed(pop_entry.incr_two);
				octant_q   <= pop_entry.octant;
				last_q     <= pop_entry.last;
			end else if (active_q) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				dec_q   <= nd;
				last_q  <= adv_last;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/midpoint_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Midpoint line rasterizer. A start command (command 0) takes two endpoints and
// returns the leftmost one as the first pixel; each advance command (command 1)
// returns the next pixel of that line, and last_pixel marks the far endpoint.
// Start commands are dropped while draw_enable is 0, and advances with no line
// in progress return nothing. While neither side stalls, the block takes one
// command and delivers one pixel per clock: the front classifies each command
// in its accept cycle, a two-entry queue holds it, and the back steps the
// decision variable with one add and compare a cycle. A command passes through
// a queue slot and the output register, which let either side stall alone.
module midpoint_line_rasterizer (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write_en,
	input  wire logic cfg_write_data,
	mlr_cmd_if.sink   cmd,
	mlr_pix_if.source pix
);

	logic                 push, pop;
	mlr_pkg::entry_t      push_entry, pop_entry;
	mlr_pkg::queue_stat_t qstat;

	mlr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.cmd            (cmd),
		.qstat          (qstat),
		.push           (push),
		.push_entry     (push_entry)
	);

	mlr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	mlr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_entry (pop_entry),
		.qstat     (qstat),
		.pop       (pop),
		.pix       (pix)
	);

endmodule

`default_nettype wire

>>> design/mlr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mlr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            cmd_ready,
	input wire logic                            pix_valid,
	input wire logic                            pix_ready,
	input wire logic [mlr_pkg::FIELD_BITS-1:0] pixel_x,
	input wire logic [mlr_pkg::FIELD_BITS-1:0] pixel_y,
	input wire logic                            last_pixel
);

	// No pixel is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !pix_valid)
		else $error("pixel offered during reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid)
		else $error("pixel withdrawn while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=>
			$stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
		else $error("pixel changed while stalled");

	// An output that stays free drains the queue enough to take a command
	a_ready_recovers: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready && $past(pix_ready) |=> cmd_ready)
		else $error("command side stuck with output free");

endmodule

bind midpoint_line_rasterizer mlr_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd.ready),
	.pix_valid  (pix.valid),
	.pix_ready  (pix.ready),
	.pixel_x    (pix.pixel_x),
	.pixel_y    (pix.pixel_y),
	.last_pixel (pix.last_pixel)
);

`default_nettype wire

>>> tb/sv/midpoint_line_rasterizer_test.sv
`timescale 1ns / 1ps

module midpoint_line_rasterizer_test;
	import mlr_pkg::*;

	localparam int COORD_MAX = (1 << FIELD_BITS) - 1;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT = 3000;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_PIXELS = 250;
	localparam int OFF_PHASE_CMDS = 60;
	localparam int MAX_PRINTED = 50;

	typedef logic [FIELD_BITS-1:0] fld_t;

	typedef struct packed {
		command_t cmd;
		fld_t     sx;
		fld_t     sy;
		fld_t     ex;
		fld_t     ey;
	} cmd_item_t;

	typedef struct packed {
		fld_t x;
		fld_t y;
		logic last;
	} pixel_t;

	typedef enum logic [1:0] {
		ROW_SILENT,
		ROW_TYPED,
		ROW_PREDICTED
	} row_check_t;

	typedef struct packed {
		logic       en;
		cmd_item_t  item;
		row_check_t chk;
		pixel_t     px;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic cfg_write_data;

	mlr_cmd_if cmd_bus ();
	mlr_pix_if pix_bus ();

	midpoint_line_rasterizer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.cmd            (cmd_bus),
		.pix            (pix_bus)
	);

	// Shadow of the rasterizer state
	logic                       draw_on;
	coord_t                     line_x;
	coord_t                     line_y;
	coord_t                     line_stop;
	logic signed [DEC_BITS-1:0] line_dec;
	logic signed [DEC_BITS-1:0] line_inc_a;
	logic signed [DEC_BITS-1:0] line_inc_b;
	octant_t                    line_oct;
	logic                       line_busy;

	pixel_t pending_pixels [$];

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int pixels_checked;
	int commands_sent;
	int enable_writes;
	int octant_hits [4];

	row_t plan [27] = '{
		'{1'b0, '{CMD_START, 11'd0, 11'd0, 11'd2047, 11'd2047}, ROW_SILENT,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b0, '{CMD_ADVANCE, 11'd2047, 11'd2047, 11'd2047, 11'd2047}, ROW_SILENT,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_SILENT,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_START, 11'd5, 11'd5, 11'd5, 11'd5}, ROW_TYPED,
			'{11'd5, 11'd5, 1'b1}},
		'{1'b1, '{CMD_START, 11'd2047, 11'd2047, 11'd2047, 11'd2047}, ROW_TYPED,
			'{11'd2047, 11'd2047, 1'b1}},
		'{1'b1, '{CMD_START, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_TYPED,
			'{11'd0, 11'd0, 1'b1}},
		'{1'b1, '{CMD_START, 11'd0, 11'd0, 11'd3, 11'd0}, ROW_TYPED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_SILENT,
			'{11'd0, 11'd0, 1'b0}},
		// vertical, up in y
		'{1'b1, '{CMD_START, 11'd10, 11'd10, 11'd10, 11'd13}, ROW_TYPED,
			'{11'd10, 11'd10, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		// vertical, down in y, abandons the line above
		'{1'b1, '{CMD_START, 11'd2047, 11'd2047, 11'd2047, 11'd2044}, ROW_TYPED,
			'{11'd2047, 11'd2047, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		// endpoints given right to left, steep down with diagonal steps
		'{1'b1, '{CMD_START, 11'd20, 11'd5, 11'd17, 11'd9}, ROW_TYPED,
			'{11'd17, 11'd9, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		// slope exactly -1 and +1
		'{1'b1, '{CMD_START, 11'd0, 11'd2047, 11'd2047, 11'd0}, ROW_TYPED,
			'{11'd0, 11'd2047, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_START, 11'd0, 11'd0, 11'd2047, 11'd2047}, ROW_TYPED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_START, 11'd100, 11'd100, 11'd102, 11'd110}, ROW_TYPED,
			'{11'd100, 11'd100, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}},
		'{1'b1, '{CMD_ADVANCE, 11'd0, 11'd0, 11'd0, 11'd0}, ROW_PREDICTED,
			'{11'd0, 11'd0, 1'b0}}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit at_far_end();
		if (line_oct == OCT_SHALLOW_UP || line_oct == OCT_SHALLOW_DOWN)
			return line_x == line_stop;
		return line_y == line_stop;
	endfunction

	// Returns 1 when the command yields a pixel; updates the shadow state
	function automatic bit rasterize(input cmd_item_t it, output pixel_t px);
		int  x0, y0, x1, y1, a, b, dy;
		bit  last;
		px = '0;
		if (it.cmd == CMD_START) begin
			if (!draw_on)
				return 1'b0;
			// keep x non-decreasing along the line
			if (it.ex < it.sx) begin
				x0 = int'(it.ex); y0 = int'(it.ey); x1 = int'(it.sx); y1 = int'(it.sy);
			end else begin
				x0 = int'(it.sx); y0 = int'(it.sy); x1 = int'(it.ex); y1 = int'(it.ey);
			end
			a = y0 - y1;
			b = x1 - x0;
			dy = y1 - y0;
			line_x = COORD_BITS'(x0);
			line_y = COORD_BITS'(y0);
			if (dy >= 0 && dy <= b) begin
				line_oct = OCT_SHALLOW_UP;
				line_dec = DEC_BITS'(2 * a + b);
				line_inc_a = DEC_BITS'(2 * a);
				line_inc_b = DEC_BITS'(2 * (a + b));
				line_stop = COORD_BITS'(x1);
			end else if (dy < 0 && dy >= -b) begin
				line_oct = OCT_SHALLOW_DOWN;
				line_dec = DEC_BITS'(2 * a - b);
				line_inc_a = DEC_BITS'(2 * a - 2 * b);
				line_inc_b = DEC_BITS'(2 * a);
				line_stop = COORD_BITS'(x1);
			end else if (dy > b) begin
				line_oct = OCT_STEEP_UP;
				line_dec = DEC_BITS'(a + 2 * b);
				line_inc_a = DEC_BITS'(2 * (a + b));
				line_inc_b = DEC_BITS'(2 * b);
				line_stop = COORD_BITS'(y1);
			end else begin
				line_oct = OCT_STEEP_DOWN;
				line_dec = DEC_BITS'(a - 2 * b);
				line_inc_a = DEC_BITS'(-2 * b);
				line_inc_b = DEC_BITS'(2 * (a - b));
				line_stop = COORD_BITS'(y1);
			end
			octant_hits[line_oct]++;
			last = at_far_end();
			line_busy = !last;
		end else begin
			if (!line_busy)
				return 1'b0;
			case (line_oct)
				OCT_SHALLOW_UP: begin
					line_x = line_x + 1'b1;
					if (line_dec <= 0) begin
						line_y = line_y + 1'b1;
						line_dec = line_dec + line_inc_b;
					end else begin
						line_dec = line_dec + line_inc_a;
					end
				end
				OCT_SHALLOW_DOWN: begin
					line_x = line_x + 1'b1;
					if (line_dec > 0) begin
						line_y = line_y - 1'b1;
						line_dec = line_dec + line_inc_a;
					end else begin
						line_dec = line_dec + line_inc_b;
					end
				end
				OCT_STEEP_UP: begin
					line_y = line_y + 1'b1;
					if (line_dec > 0) begin
						line_x = line_x + 1'b1;
						line_dec = line_dec + line_inc_a;
					end else begin
						line_dec = line_dec + line_inc_b;
					end
				end
				default: begin
					line_y = line_y - 1'b1;
					if (line_dec <= 0) begin
						line_x = line_x + 1'b1;
						line_dec = line_dec + line_inc_b;
					end else begin
						line_dec = line_dec + line_inc_a;
					end
				end
			endcase
			last = at_far_end();
			if (last)
				line_busy = 1'b0;
		end
		px = '{line_x, line_y, last};
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_cmd(input cmd_item_t it, input row_check_t chk, input pixel_t typed,
			output bit produced);
		pixel_t px;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= it.cmd;
		cmd_bus.start_x <= it.sx;
		cmd_bus.start_y <= it.sy;
		cmd_bus.end_x <= it.ex;
		cmd_bus.end_y <= it.ey;
		do @(posedge clk); while (!cmd_bus.ready);
		produced = rasterize(it, px);
		case (chk)
			ROW_TYPED: pending_pixels.push_back(typed);
			ROW_PREDICTED: if (produced) pending_pixels.push_back(px);
			default: ;
		endcase
		commands_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every pixel is back and the pipeline is empty
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		do @(negedge clk); while (pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_draw_enable(input logic v);
		settle();
		cfg_write_data <= v;
		cfg_write_en <= 1'b1;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		draw_on = v;
		enable_writes++;
	endtask

	function automatic fld_t near_coord(input fld_t c, input int span);
		int lo, hi;
		lo = int'(c) - span;
		hi = int'(c) + span;
		if (lo < 0)
			lo = 0;
		if (hi > COORD_MAX)
			hi = COORD_MAX;
		return fld_t'($urandom_range(hi, lo));
	endfunction

	function automatic cmd_item_t random_advance();
		return '{CMD_ADVANCE, fld_t'($urandom_range(COORD_MAX)), fld_t'($urandom_range(COORD_MAX)),
			fld_t'($urandom_range(COORD_MAX)), fld_t'($urandom_range(COORD_MAX))};
	endfunction

	// Receiver stalls
	initial begin
		pix_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			pix_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Pixel checker
	initial begin
		pixel_t want;
		forever begin
			@(posedge clk);
			if (pix_bus.valid && pix_bus.ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
						pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.last_pixel));
				end else begin
					want = pending_pixels.pop_front();
					if (pix_bus.pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x got %0d want %0d",
							pix_bus.pixel_x, want.x));
					if (pix_bus.pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y got %0d want %0d",
							pix_bus.pixel_y, want.y));
					if (pix_bus.last_pixel !== want.last)
						report_mismatch($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
							pix_bus.last_pixel, want.last, want.x, want.y));
				end
				pixels_checked++;
			end
		end
	end

	// Watchdog: end the run after too long without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles, %0d pixels outstanding",
			QUIET_LIMIT, pending_pixels.size());
		$display("midpoint_line_rasterizer_test: done, errors");
		$finish;
	end

	initial begin
		cmd_item_t it;
		pixel_t    no_px;
		bit        produced;
		int        phase, phase_pixels, phase_lines;
		int        span, span_y, dxv, dyv, n, m, r;
		logic      phase_en [NUM_PHASES];

		// drawing is on for the no-stall, sender-idle and receiver-stall phases; the mixed-idle phases run with it off
		phase_en = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
		no_px = '0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_START;
		cmd_bus.start_x = '0;
		cmd_bus.start_y = '0;
		cmd_bus.end_x = '0;
		cmd_bus.end_y = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		pixels_checked = 0;
		commands_sent = 0;
		enable_writes = 0;
		octant_hits = '{0, 0, 0, 0};
		draw_on = 1'b0;
		line_x = '0;
		line_y = '0;
		line_stop = '0;
		line_dec = '0;
		line_inc_a = '0;
		line_inc_b = '0;
		line_oct = OCT_SHALLOW_UP;
		line_busy = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].en != draw_on)
				set_draw_enable(plan[i].en);
			send_cmd(plan[i].item, plan[i].chk, plan[i].px, produced);
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			set_draw_enable(phase_en[phase]);
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 57; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 57; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase

			if (!phase_en[phase]) begin
				// starts are dropped; advances may still finish an open line
				repeat (OFF_PHASE_CMDS) begin
					if ($urandom_range(1) == 0)
						it = '{CMD_START, fld_t'($urandom_range(COORD_MAX)),
							fld_t'($urandom_range(COORD_MAX)), fld_t'($urandom_range(COORD_MAX)),
							fld_t'($urandom_range(COORD_MAX))};
					else
						it = random_advance();
					send_cmd(it, ROW_PREDICTED, no_px, produced);
				end
				continue;
			end

			phase_pixels = 0;
			phase_lines = 0;
			while (phase_pixels < PHASE_PIXELS) begin
				r = $urandom_range(99);
				span = (r < 85) ? $urandom_range(15) :
					(r < 98) ? $urandom_range(120) : $urandom_range(400);
				span_y = $urandom_range(span);
				if ($urandom_range(1))
					begin n = span; span = span_y; span_y = n; end
				it.cmd = CMD_START;
				it.sx = fld_t'($urandom_range(COORD_MAX));
				it.sy = fld_t'($urandom_range(COORD_MAX));
				if ($urandom_range(19) == 0) begin
					it.ex = fld_t'($urandom_range(COORD_MAX));
					it.ey = fld_t'($urandom_range(COORD_MAX));
				end else begin
					it.ex = near_coord(it.sx, span);
					it.ey = near_coord(it.sy, span_y);
				end
				dxv = (it.ex > it.sx) ? int'(it.ex) - int'(it.sx) : int'(it.sx) - int'(it.ex);
				dyv = (it.ey > it.sy) ? int'(it.ey) - int'(it.sy) : int'(it.sy) - int'(it.ey);
				n = (dxv > dyv) ? dxv : dyv;
				m = $urandom_range(99);
				if (n > 500)
					n = $urandom_range(10);
				else if (m >= 80 && m < 90)
					n = $urandom_range(n);
				else if (m >= 90)
					n = n + $urandom_range(3, 1);
				send_cmd(it, ROW_PREDICTED, no_px, produced);
				if (produced)
					phase_pixels++;
				repeat (n) begin
					send_cmd(random_advance(), ROW_PREDICTED, no_px, produced);
					if (produced)
						phase_pixels++;
				end
				phase_lines++;
				if (phase_lines == 3 || $urandom_range(39) == 0)
					settle();
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("summary: %0d commands, %0d pixels checked, %0d phases, %0d enable writes",
			commands_sent, pixels_checked, NUM_PHASES, enable_writes);
		$display("summary: lines begun shallow up %0d, shallow down %0d, steep up %0d, steep down %0d",
			octant_hits[0], octant_hits[1], octant_hits[2], octant_hits[3]);
		if (error_count == 0)
			$display("midpoint_line_rasterizer_test: done, clean");
		else
			$display("midpoint_line_rasterizer_test: done, errors");
		$finish;
	end

endmodule
